// ===== rtl/ane_pkg.sv =====
package ane_pkg;

  localparam logic [7:0] TypeShortName = 8'h08;
  localparam logic [7:0] TypeFullName  = 8'h09;
  localparam logic [7:0] MaxNameLenRst = 8'd248;

  localparam logic [1:0] StNameByte  = 2'd0;
  localparam logic [1:0] StEmptyName = 2'd1;
  localparam logic [1:0] StUnknown   = 2'd2;

  typedef enum logic [2:0] {
    PH_DONE = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_NAME = 3'd3,
    PH_SKIP = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_record;
    logic [7:0] record_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic [1:0] status;
    logic       last_of_run;
  } out_item_t;

endpackage

// ===== rtl/ane_parser.sv =====
module ane_parser import ane_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  input  logic [7:0] max_name_len_i,
  output logic      emit_o,
  output out_item_t result_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] offset_q, offset_d;
  logic [7:0] left_q, left_d;

  phase_e     ph;
  logic [7:0] o;
  logic [7:0] left;
  logic [7:0] left_dec;
  logic [8:0] field_end_pos;
  logic       is_name_type;
  logic       rec_over;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DONE;
      offset_q <= '0;
      left_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      offset_q <= offset_d;
      left_q   <= left_d;
    end
  end

  always_comb begin
    ph            = item_i.first_of_record ? PH_LEN : phase_q;
    o             = item_i.first_of_record ? 8'd0 : offset_q;
    left          = item_i.first_of_record ? 8'd0 : left_q;
    left_dec      = left - 8'd1;
    field_end_pos = {1'b0, o} + {1'b0, item_i.data_byte} + 9'd1;
    is_name_type  = (item_i.data_byte == TypeShortName) ||
                    (item_i.data_byte == TypeFullName);
    // no room after this byte for another field
    rec_over      = ({1'b0, o} + 9'd1) >= {1'b0, item_i.record_length};

    phase_d  = phase_q;
    offset_d = offset_q;
    left_d   = left_q;
    emit_o   = 1'b0;
    result_o = '0;

    if (fire_i) begin
      phase_d  = ph;
      offset_d = o;
      left_d   = left;
      if (ph != PH_DONE) begin
        if (o >= item_i.record_length) begin
          phase_d              = PH_DONE;
          emit_o               = 1'b1;
          result_o.status      = StUnknown;
          result_o.last_of_run = 1'b1;
        end else begin
          offset_d = o + 8'd1;
          unique case (ph)
            PH_LEN: begin
              if (item_i.data_byte == 8'd0 ||
                  field_end_pos > {1'b0, item_i.record_length}) begin
                phase_d              = PH_DONE;
                emit_o               = 1'b1;
                result_o.status      = StUnknown;
                result_o.last_of_run = 1'b1;
              end else begin
                left_d  = item_i.data_byte;
                phase_d = PH_TYPE;
              end
            end
            PH_TYPE: begin
              left_d = left_dec;
              if (is_name_type) begin
                if (left_dec > max_name_len_i) begin
                  phase_d              = PH_DONE;
                  emit_o               = 1'b1;
                  result_o.status      = StUnknown;
                  result_o.last_of_run = 1'b1;
                end else if (left_dec == 8'd0) begin
                  phase_d              = PH_DONE;
                  emit_o               = 1'b1;
                  result_o.status      = StEmptyName;
                  result_o.last_of_run = 1'b1;
                end else begin
                  phase_d = PH_NAME;
                end
              end else if (left_dec == 8'd0) begin
                if (rec_over) begin
                  phase_d              = PH_DONE;
                  emit_o               = 1'b1;
                  result_o.status      = StUnknown;
                  result_o.last_of_run = 1'b1;
                end else begin
                  phase_d = PH_LEN;
                end
              end else begin
                phase_d = PH_SKIP;
              end
            end
            PH_NAME: begin
              left_d               = left_dec;
              emit_o               = 1'b1;
              result_o.name_byte   = item_i.data_byte;
              result_o.status      = StNameByte;
              result_o.last_of_run = (left_dec == 8'd0);
              if (left_dec == 8'd0) begin
                phase_d = PH_DONE;
              end
            end
            PH_SKIP: begin
              left_d = left_dec;
              if (left_dec == 8'd0) begin
                if (rec_over) begin
                  phase_d              = PH_DONE;
                  emit_o               = 1'b1;
                  result_o.status      = StUnknown;
                  result_o.last_of_run = 1'b1;
                end else begin
                  phase_d = PH_LEN;
                end
              end
            end
            default: begin
              phase_d = PH_DONE;
            end
          endcase
        end
      end
    end
  end

endmodule

// ===== rtl/ane_out_reg.sv =====
module ane_out_reg import ane_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  logic      valid_i,
  input  out_item_t item_i,
  input  logic      out_stall_i,
  output logic      out_free_o,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  logic      valid_q;
  out_item_t item_q;

  // slot frees up when empty or when its item is taken this cycle
  assign out_free_o  = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free_o) begin
      valid_q <= load_i && valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free_o && load_i && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== rtl/adv_data_name_extractor_unit.sv =====
// Local-name extractor for advertising records: takes one record byte per
// cycle and returns the first shortened or complete local name as a run of
// name bytes (the last marked), or a single empty-name or unknown status.
// One item is accepted every cycle when the result side is not stalled; an
// item's result is set by the single parse stage between the input register
// and the result register, and is loaded into the result register when the
// item leaves the input register.
// max_name_len may only be written while no item is in flight.
module adv_data_name_extractor_unit import ane_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic       in_valid_q;
  in_item_t   in_item_q;
  logic [7:0] max_name_len_q;
  logic       out_free;
  logic       fire;
  logic       emit;
  out_item_t  result;

  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_name_len_q <= MaxNameLenRst;
    end else if (cfg_we_i) begin
      max_name_len_q <= cfg_wdata_i;
    end
  end

  ane_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .item_i         (in_item_q),
    .max_name_len_i (max_name_len_q),
    .emit_o         (emit),
    .result_o       (result)
  );

  ane_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .valid_i     (emit),
    .item_i      (result),
    .out_stall_i (out_stall_i),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  a_status_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != StNameByte |->
      out_item_o.name_byte == 8'd0 && out_item_o.last_of_run)
    else $error("status result carries name byte or lacks last flag");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  a_blocked_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(in_item_q))
    else $error("blocked item lost from input register");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> max_name_len_q == $past(cfg_wdata_i))
    else $error("config write not taken");

endmodule

// ===== bench/adv_data_name_extractor_unit_tb.sv =====
module adv_data_name_extractor_unit_tb;
  import ane_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 20;
  localparam int LongHold = 80;

  typedef logic [7:0] byte_q_t[$];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  // parser state mirrored on the bench side
  phase_e cur_phase = PH_DONE;
  logic [7:0] cur_off = '0;
  logic [7:0] field_left = '0;
  logic [7:0] name_limit = MaxNameLenRst;

  in_item_t byte_feed_q[$];
  out_item_t name_expect_q[$];

  int items_queued = 0;
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  int hold_reqs = 0;
  int holds_done = 0;
  int hold_left = 0;
  int in_gap = 0;
  int out_gap = 0;

  adv_data_name_extractor_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic bit give_up(output out_item_t res);
    cur_phase = PH_DONE;
    res = '0;
    res.status = StUnknown;
    res.last_of_run = 1'b1;
    return 1'b1;
  endfunction

  // end of a non-name field: either another field follows or the record is used up
  function automatic bit field_done(input logic [7:0] rlen, output out_item_t res);
    res = '0;
    if (int'(cur_off) + 1 >= int'(rlen)) return give_up(res);
    cur_phase = PH_LEN;
    return 1'b0;
  endfunction

  function automatic bit parse_byte(input in_item_t it, output out_item_t res);
    bit hit;
    hit = 1'b0;
    res = '0;
    if (it.first_of_record) begin
      cur_phase = PH_LEN;
      cur_off = '0;
      field_left = '0;
    end
    if (cur_phase != PH_DONE) begin
      if (cur_off >= it.record_length) begin
        hit = give_up(res);
      end else begin
        case (cur_phase)
          PH_LEN: begin
            if (it.data_byte == 8'd0 ||
                int'(cur_off) + int'(it.data_byte) + 1 > int'(it.record_length)) begin
              hit = give_up(res);
            end else begin
              field_left = it.data_byte;
              cur_phase = PH_TYPE;
            end
          end
          PH_TYPE: begin
            field_left = field_left - 8'd1;
            if (it.data_byte == TypeShortName || it.data_byte == TypeFullName) begin
              if (field_left > name_limit) begin
                hit = give_up(res);
              end else if (field_left == 8'd0) begin
                cur_phase = PH_DONE;
                res.status = StEmptyName;
                res.last_of_run = 1'b1;
                hit = 1'b1;
              end else begin
                cur_phase = PH_NAME;
              end
            end else if (field_left == 8'd0) begin
              hit = field_done(it.record_length, res);
            end else begin
              cur_phase = PH_SKIP;
            end
          end
          PH_NAME: begin
            field_left = field_left - 8'd1;
            res.name_byte = it.data_byte;
            res.status = StNameByte;
            res.last_of_run = (field_left == 8'd0);
            if (field_left == 8'd0) cur_phase = PH_DONE;
            hit = 1'b1;
          end
          PH_SKIP: begin
            field_left = field_left - 8'd1;
            if (field_left == 8'd0) hit = field_done(it.record_length, res);
          end
          default: cur_phase = PH_DONE;
        endcase
        cur_off = cur_off + 8'd1;
      end
    end
    return hit;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item <= '0;
      in_gap <= 0;
    end else begin
      out_item_t res;
      if (in_valid && !in_stall) begin
        if (parse_byte(in_item, res)) name_expect_q.push_back(res);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (byte_feed_q.size() != 0 && idle_on && $urandom_range(0, 9) == 0) begin
          in_valid <= 1'b0;
          in_gap <= $urandom_range(0, 7);
        end else if (byte_feed_q.size() != 0) begin
          in_valid <= 1'b1;
          in_item <= byte_feed_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      out_gap <= 0;
    end else begin
      out_item_t want;
      if (out_valid && !out_stall) begin
        if (name_expect_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 40)
            $display("%0t: expected no result, got byte %02h status %0d last %0b",
                     $time, out_item.name_byte, out_item.status, out_item.last_of_run);
        end else begin
          want = name_expect_q.pop_front();
          if (out_item.name_byte !== want.name_byte || out_item.status !== want.status ||
              out_item.last_of_run !== want.last_of_run) begin
            errors <= errors + 1;
            if (errors < 40)
              $display("%0t: expected byte %02h status %0d last %0b, got byte %02h status %0d last %0b",
                       $time, want.name_byte, want.status, want.last_of_run,
                       out_item.name_byte, out_item.status, out_item.last_of_run);
          end
        end
      end
      if (holds_done != hold_reqs) begin
        holds_done <= hold_reqs;
        hold_left <= LongHold;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        out_gap <= $urandom_range(0, 7);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_stray(input logic [7:0] d, input logic [7:0] rlen);
    in_item_t it;
    it.data_byte = d;
    it.first_of_record = 1'b0;
    it.record_length = rlen;
    byte_feed_q.push_back(it);
    items_queued++;
  endtask

  task automatic add_record(input byte_q_t rec, input logic [7:0] rlen);
    in_item_t it;
    foreach (rec[i]) begin
      it.data_byte = rec[i];
      it.first_of_record = (i == 0);
      it.record_length = rlen;
      byte_feed_q.push_back(it);
    end
    items_queued += rec.size();
  endtask

  task automatic add_field(ref byte_q_t rec, input logic [7:0] ftype, input int n);
    rec.push_back(8'(n + 1));
    rec.push_back(ftype);
    repeat (n) rec.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_random_record();
    byte_q_t rec;
    logic [7:0] t;
    int kind;
    int nlen;
    int rlen;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 7) == 0)
      add_stray(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 3)) begin
      do t = 8'($urandom_range(0, 255)); while (t == TypeShortName || t == TypeFullName);
      add_field(rec, t, $urandom_range(0, 3));
    end
    if (kind != 7) begin
      nlen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 5);
      add_field(rec, $urandom_range(0, 1) ? TypeFullName : TypeShortName, nlen);
      repeat ($urandom_range(0, 2))
        add_field(rec, 8'($urandom_range(0, 255)), $urandom_range(0, 2));
    end else if (rec.size() == 0) begin
      add_field(rec, 8'h01, $urandom_range(0, 3));
    end
    rlen = rec.size();
    if (kind == 8) begin
      // record length is perturbed and may disagree with the bytes sent
      rlen = rlen + $urandom_range(0, 6) - 3;
      if (rlen < 0) rlen = 0;
      if ($urandom_range(0, 9) == 0) rlen = $urandom_range(0, 255);
    end else if (kind == 9) begin
      rec[$urandom_range(0, rec.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 0) rec = rec[0:$urandom_range(0, rec.size() - 1)];
    end
    add_record(rec, 8'(rlen));
  endtask

  task automatic run_random(input int n);
    int start;
    start = items_queued;
    while (items_queued - start < n) add_random_record();
  endtask

  task automatic wait_drained();
    while (byte_feed_q.size() != 0 || in_valid || name_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_name_limit(input logic [7:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    name_limit = v;
  endtask

  initial begin
    byte_q_t long_rec;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed cases, reset name limit
    add_stray(8'hFF, 8'hFF);                                // no record open yet
    add_record('{8'h05}, 8'd0);                             // zero record length
    add_record('{8'h00}, 8'd4);                             // zero length byte
    add_record('{8'h03}, 8'd3);                             // field overruns record
    add_record('{8'h01, TypeFullName}, 8'd2);               // empty name
    add_record('{8'h04, TypeShortName, 8'h00, 8'hFF, 8'h80}, 8'd5);
    add_record('{8'h02, 8'h01, 8'h06, 8'h02, TypeFullName, 8'h41}, 8'd6);
    add_record('{8'h02, 8'h7F, 8'h55}, 8'd3);               // no name in record
    add_record('{8'h01, 8'hFF, 8'h01}, 8'd3);               // second field overruns
    add_record('{8'h05, 8'h01}, 8'd10);                     // dropped by next record start
    add_record('{8'hFA, TypeShortName}, 8'd252);            // name one over the limit
    add_record('{8'h03}, 8'd5);
    add_stray(8'h00, 8'd1);                                 // record length shrinks mid-record
    wait_drained();

    // result side holds off while the sender keeps going
    run_random(100);
    hold_reqs++;
    wait_drained();

    set_name_limit(8'd0);
    run_random(70);
    wait_drained();

    set_name_limit(8'd255);
    run_random(70);
    wait_drained();

    set_name_limit(8'($urandom_range(1, 8)));
    run_random(100);
    wait_drained();

    // longest name that still fits the reset limit
    set_name_limit(MaxNameLenRst);
    long_rec.push_back(8'd249);
    long_rec.push_back(TypeFullName);
    repeat (248) long_rec.push_back(8'($urandom_range(0, 255)));
    add_record(long_rec, 8'd250);
    add_record('{8'hFA, TypeFullName}, 8'd255);
    run_random(20);
    wait_drained();

    idle_on = 1'b0;
    set_name_limit(8'($urandom_range(0, 255)));
    run_random(70);
    wait_drained();

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== adv_data_name_extractor_unit.f =====
rtl/ane_pkg.sv
rtl/ane_parser.sv
rtl/ane_out_reg.sv
rtl/adv_data_name_extractor_unit.sv
bench/adv_data_name_extractor_unit_tb.sv
